@@ hdl/vgcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgcw_pkg
// Shared types, constants and elaboration-time table builders for the voxel
// graph-cut weight generator.
// ----------------------------------------------------------------------------
package vgcw_pkg;

    localparam int unsigned LEVELS       = 200;
    localparam int unsigned LIMIT_BITS   = 17;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned NODE_W       = 27;
    localparam int unsigned SOURCE_W     = 15;
    localparam int unsigned SINK_W       = 9;
    localparam int unsigned WEIGHT_W     = 8;
    localparam int unsigned CFG_W        = 10;
    localparam int unsigned PADDR_W      = 4;
    localparam int unsigned PDATA_W      = 32;

    localparam logic [SINK_W-1:0]   SINK_COST    = 9'd400;
    localparam logic [SOURCE_W-1:0] SOURCE_LIMIT = 15'd32767;
    localparam logic [CFG_W-1:0]    DIM_RESET    = 10'd512;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_SLICES  = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0]   node_index;
        logic [SOURCE_W-1:0] source_weight;
        logic [WEIGHT_W-1:0] left_weight;
        logic                left_valid;
        logic [WEIGHT_W-1:0] up_weight;
        logic                up_valid;
        logic [WEIGHT_W-1:0] back_weight;
        logic                back_valid;
        logic                volume_done;
    } t_result;

    // restoring division, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atanh(a/b) in Q56 by series
    function automatic logic [63:0] f_atanh(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        logic [63:0] sum;
        t   = f_udiv(a << 56, b);
        sum = '0;
        for (int n = 0; n < 64; n++) begin
            if (t != 0) begin
                sum = sum + f_udiv(t, 64'(2 * n + 1));
                t   = f_udiv(t * a, b);
                t   = f_udiv(t * a, b);
            end
        end
        return sum;
    endfunction

    function automatic logic [16:0] f_isqrt(input logic [31:0] v);
        logic [16:0] root;
        logic [33:0] sq;
        root = '0;
        for (int i = 15; i >= 0; i--) begin
            sq = 34'(root | (17'd1 << i)) * 34'(root | (17'd1 << i));
            if (sq <= 34'(v)) begin
                root = root | (17'd1 << i);
            end
        end
        return root;
    endfunction

    // largest |d| giving each level, level k at bits [17k-1 -: 17], k = 1..200
    function automatic logic [LEVELS*LIMIT_BITS-1:0] f_limit_table(input int unsigned fs);
        logic [LEVELS*LIMIT_BITS-1:0] tbl;
        logic [63:0]  ln2;
        logic [63:0]  lnk;
        logic [63:0]  m;
        logic [63:0]  e;
        logic [63:0]  fs2;
        logic [127:0] prod;
        logic [127:0] thr;
        logic [16:0]  lim;
        tbl = '0;
        ln2 = 64'd2 * f_atanh(64'd1, 64'd3);
        fs2 = 64'(fs) * 64'(fs);
        for (int k = 1; k <= LEVELS; k++) begin
            m = 64'(k);
            e = '0;
            for (int i = 0; i < 8; i++) begin
                if (m <= 64'd100) begin
                    m = m << 1;
                    e = e + 64'd1;
                end
            end
            lnk  = e * ln2 + 64'd2 * f_atanh(64'd200 - m, 64'd200 + m);
            prod = 128'(fs2) * 128'(lnk);
            thr  = prod >> 59;
            if (thr >= 128'h1_0000_0000) begin
                lim = 17'h1_0000;
            end else begin
                lim = f_isqrt(thr[31:0]);
            end
            tbl[k*LIMIT_BITS-1 -: LIMIT_BITS] = lim;
        end
        return tbl;
    endfunction

endpackage
`default_nettype wire

@@ hdl/vgcw_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgcw_ram
// Generic single-write, single-read synchronous RAM, registered read-first.
// ----------------------------------------------------------------------------
module vgcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/vgcw_link.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgcw_link
// Gaussian link weight: absolute difference, compare against the level
// limits, then encode the thermometer into a count. Two register stages.
// ----------------------------------------------------------------------------
module vgcw_link
    import vgcw_pkg::*;
#(
    parameter logic [LEVELS*LIMIT_BITS-1:0] LIMITS = '0
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [SAMPLE_W-1:0] i_a,
    input  wire logic [SAMPLE_W-1:0] i_b,
    output logic      [WEIGHT_W-1:0] o_weight
);

    logic [SAMPLE_W-1:0] r_d;
    logic [LEVELS-1:0]   r_therm;
    logic [LEVELS-1:0]   n_therm;
    logic [WEIGHT_W-1:0] w_cand;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
            r_therm <= n_therm;
        end
    end

    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            n_therm[k] = {1'b0, r_d} <= LIMITS[(k+1)*LIMIT_BITS-1 -: LIMIT_BITS];
        end
    end

    // thermometer is monotone: find the highest set level bit by bit
    always_comb begin
        o_weight = '0;
        for (int b = WEIGHT_W - 1; b >= 0; b--) begin
            w_cand = o_weight | (WEIGHT_W'(1) << b);
            if (int'(w_cand) <= LEVELS) begin
                if (r_therm[w_cand - WEIGHT_W'(1)]) begin
                    o_weight = w_cand;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/voxel_graph_cut_weight_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_graph_cut_weight_generator
// Graph-cut node and link weights for a raster-ordered voxel stream.
// ----------------------------------------------------------------------------
// One voxel is taken per clock while o_stall is low; the sustained rate
// without output stalls is one item per cycle, set by the slice store,
// which is kept as two identical RAM copies so that the upper and the
// previous-slice neighbours are read and the new sample is written in the
// same cycle. The store is not cleared after reset: it needs no clearing pass
// and holds valid data once a slice has streamed in. A two-entry output
// register keeps the input side running while a result waits. Registers:
// columns at 0x0, rows at 0x4, slices at 0x8; write them while idle.
// ----------------------------------------------------------------------------
module voxel_graph_cut_weight_generator
    import vgcw_pkg::*;
#(
    parameter int          MAX_COLUMNS = 512,
    parameter int          MAX_ROWS    = 512,
    parameter int          MAX_SLICES  = 512,
    parameter int          SAMPLE_BITS = 16,
    parameter int unsigned FULL_SCALE  = 65535
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [NODE_W-1:0]        o_node_index,
    output logic [SOURCE_W-1:0]      o_source_weight,
    output logic [SINK_W-1:0]        o_sink_weight,
    output logic [WEIGHT_W-1:0]      o_left_weight,
    output logic                     o_left_valid,
    output logic [WEIGHT_W-1:0]      o_up_weight,
    output logic                     o_up_valid,
    output logic [WEIGHT_W-1:0]      o_back_weight,
    output logic                     o_back_valid,
    output logic                     o_volume_done,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int CLW   = $clog2(MAX_COLUMNS + 1);
    localparam int RLW   = $clog2(MAX_ROWS + 1);
    localparam int SLW   = $clog2(MAX_SLICES + 1);
    localparam int CPW   = $clog2(MAX_COLUMNS);
    localparam int RPW   = $clog2(MAX_ROWS);
    localparam int SPW   = $clog2(MAX_SLICES);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ARW   = $clog2(DEPTH + 1);
    localparam int PSW   = RPW + CLW + 1;
    localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [LEVELS*LIMIT_BITS-1:0] LIMITS = f_limit_table(FULL_SCALE);

    // configuration
    logic [CFG_W-1:0] r_columns, r_rows, r_slices;
    logic [CLW-1:0]   w_cols;
    logic [RLW-1:0]   w_rws;
    logic [SLW-1:0]   w_sls;
    logic [ARW-1:0]   r_area;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= DIM_RESET;
            r_rows    <= DIM_RESET;
            r_slices  <= DIM_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_COLUMNS: r_columns <= pwdata[CFG_W-1:0];
                REG_ROWS:    r_rows    <= pwdata[CFG_W-1:0];
                REG_SLICES:  r_slices  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COLUMNS: prdata = PDATA_W'(r_columns);
            REG_ROWS:    prdata = PDATA_W'(r_rows);
            REG_SLICES:  prdata = PDATA_W'(r_slices);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        if (r_columns == '0) begin
            w_cols = CLW'(1);
        end else if (int'(r_columns) > MAX_COLUMNS) begin
            w_cols = CLW'(MAX_COLUMNS);
        end else begin
            w_cols = CLW'(r_columns);
        end
        if (r_rows == '0) begin
            w_rws = RLW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            w_rws = RLW'(MAX_ROWS);
        end else begin
            w_rws = RLW'(r_rows);
        end
        if (r_slices == '0) begin
            w_sls = SLW'(1);
        end else if (int'(r_slices) > MAX_SLICES) begin
            w_sls = SLW'(MAX_SLICES);
        end else begin
            w_sls = SLW'(r_slices);
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= ARW'(w_rws * w_cols);
    end

    // pipeline control
    logic w_en, w_accept, w_deliver, w_take;
    logic r_skid_valid, r_out_valid;

    assign w_en      = !r_skid_valid;
    assign o_stall   = r_skid_valid;
    assign w_accept  = i_valid && w_en;

    // position counters
    logic [CPW-1:0] r_col;
    logic [RPW-1:0] r_row;
    logic [SPW-1:0] r_slc;
    logic [CPW-1:0] w_c;
    logic [RPW-1:0] w_r;
    logic [SPW-1:0] w_z;
    logic [RPW+CLW-1:0] w_rowbase;
    logic [PSW-1:0] w_psum;
    logic [AW-1:0]  w_p, w_p_up;
    logic           w_last_c, w_last_r, w_last_z;
    logic [SAMPLE_W-1:0] w_s;
    logic [SAMPLE_W-1:0] r_left_sample;

    assign w_c = ({1'b0, r_col} >= (CPW+1)'(w_cols)) ? '0 : r_col;
    assign w_r = ({1'b0, r_row} >= (RPW+1)'(w_rws))  ? '0 : r_row;
    assign w_z = ({1'b0, r_slc} >= (SPW+1)'(w_sls))  ? '0 : r_slc;
    assign w_rowbase = w_r * w_cols;
    assign w_psum    = PSW'(w_rowbase) + PSW'(w_c);
    assign w_p       = w_psum[AW-1:0];
    assign w_p_up    = w_p - AW'(w_cols);
    assign w_last_c  = ((CLW+1)'(w_c) + (CLW+1)'(1)) == (CLW+1)'(w_cols);
    assign w_last_r  = ((RLW+1)'(w_r) + (RLW+1)'(1)) == (RLW+1)'(w_rws);
    assign w_last_z  = ((SLW+1)'(w_z) + (SLW+1)'(1)) == (SLW+1)'(w_sls);
    assign w_s       = i_sample & SMASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_slc         <= '0;
            r_left_sample <= '0;
        end else if (w_accept) begin
            r_left_sample <= w_s;
            if (w_last_c) begin
                r_col <= '0;
                if (w_last_r) begin
                    r_row <= '0;
                    r_slc <= w_last_z ? '0 : w_z + SPW'(1);
                end else begin
                    r_row <= w_r + RPW'(1);
                    r_slc <= w_z;
                end
            end else begin
                r_col <= w_c + CPW'(1);
                r_row <= w_r;
                r_slc <= w_z;
            end
        end
    end

    // slice store, two copies for two read ports
    logic [SAMPLE_W-1:0] w_up_sample, w_back_sample;

    vgcw_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store_up (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_p),
        .i_wdata (w_s),
        .i_re    (w_accept),
        .i_raddr (w_p_up),
        .o_rdata (w_up_sample)
    );

    vgcw_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store_back (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_p),
        .i_wdata (w_s),
        .i_re    (w_accept),
        .i_raddr (w_p),
        .o_rdata (w_back_sample)
    );

    // stage 1
    logic                r_v1;
    logic [SAMPLE_W-1:0] r_s1_sample, r_s1_left;
    logic [AW-1:0]       r_s1_p;
    logic [SPW-1:0]      r_s1_z;
    logic                r_s1_lv, r_s1_uv, r_s1_bv, r_s1_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= w_s;
            r_s1_left   <= r_left_sample;
            r_s1_p      <= w_p;
            r_s1_z      <= w_z;
            r_s1_lv     <= w_c != '0;
            r_s1_uv     <= w_r != '0;
            r_s1_bv     <= w_z != '0;
            r_s1_done   <= w_last_c && w_last_r && w_last_z;
        end
    end

    // link weights, ready at stage 3
    logic [WEIGHT_W-1:0] w_left_w, w_up_w, w_back_w;

    vgcw_link #(.LIMITS(LIMITS)) u_link_left (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_a      (r_s1_sample),
        .i_b      (r_s1_left),
        .o_weight (w_left_w)
    );

    vgcw_link #(.LIMITS(LIMITS)) u_link_up (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_a      (r_s1_sample),
        .i_b      (w_up_sample),
        .o_weight (w_up_w)
    );

    vgcw_link #(.LIMITS(LIMITS)) u_link_back (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_a      (r_s1_sample),
        .i_b      (w_back_sample),
        .o_weight (w_back_w)
    );

    // stages 2 and 3
    logic                r_v2, r_v3;
    t_result             r_s2, r_s3;
    t_result             n_s2, w_new;
    logic [SAMPLE_W+4:0] w_src_full;
    logic [NODE_W-1:0]   w_node;

    assign w_src_full = ((SAMPLE_W+5)'(r_s1_sample) * (SAMPLE_W+5)'(25)) >> 5;
    assign w_node     = NODE_W'(r_s1_z * r_area + (SPW+ARW)'(r_s1_p));

    always_comb begin
        n_s2               = '0;
        n_s2.node_index    = w_node;
        n_s2.source_weight = (w_src_full > (SAMPLE_W+5)'(SOURCE_LIMIT)) ?
                             SOURCE_LIMIT : w_src_full[SOURCE_W-1:0];
        n_s2.left_valid    = r_s1_lv;
        n_s2.up_valid      = r_s1_uv;
        n_s2.back_valid    = r_s1_bv;
        n_s2.volume_done   = r_s1_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2 <= n_s2;
            r_s3 <= r_s2;
        end
    end

    always_comb begin
        w_new             = r_s3;
        w_new.left_weight = r_s3.left_valid ? w_left_w : '0;
        w_new.up_weight   = r_s3.up_valid   ? w_up_w   : '0;
        w_new.back_weight = r_s3.back_valid ? w_back_w : '0;
    end

    // output register with skid entry
    t_result r_out, r_skid;

    assign w_deliver = w_en && r_v3;
    assign w_take    = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_deliver;
            end
        end else if (w_deliver) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_skid_valid ? r_skid : w_new;
        end else if (w_deliver) begin
            if (r_out_valid) begin
                r_skid <= w_new;
            end else begin
                r_out <= w_new;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_node_index    = r_out.node_index;
    assign o_source_weight = r_out.source_weight;
    assign o_sink_weight   = SINK_COST;
    assign o_left_weight   = r_out.left_weight;
    assign o_left_valid    = r_out.left_valid;
    assign o_up_weight     = r_out.up_weight;
    assign o_up_valid      = r_out.up_valid;
    assign o_back_weight   = r_out.back_weight;
    assign o_back_valid    = r_out.back_valid;
    assign o_volume_done   = r_out.volume_done;

endmodule
`default_nettype wire

@@ hdl/vgcw_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vgcw_checker
// Port-level checks for the voxel graph-cut weight generator.
// ----------------------------------------------------------------------------
module vgcw_checker
    import vgcw_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [NODE_W-1:0]   o_node_index,
    input wire logic [SINK_W-1:0]   o_sink_weight,
    input wire logic [WEIGHT_W-1:0] o_left_weight,
    input wire logic                o_left_valid,
    input wire logic [WEIGHT_W-1:0] o_up_weight,
    input wire logic                o_up_valid,
    input wire logic [WEIGHT_W-1:0] o_back_weight,
    input wire logic                o_back_valid
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output active after reset");

    a_no_link_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_valid || o_left_weight == '0) &&
                    (o_up_valid || o_up_weight == '0) &&
                    (o_back_valid || o_back_weight == '0))
        else $error("weight on a missing link");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_left_weight <= WEIGHT_W'(LEVELS) && o_up_weight <= WEIGHT_W'(LEVELS) &&
                    o_back_weight <= WEIGHT_W'(LEVELS) && o_sink_weight == SINK_COST)
        else $error("weight out of range");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_node_index == '0 |-> !o_left_valid && !o_up_valid && !o_back_valid)
        else $error("first voxel has a neighbour");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_node_index))
        else $error("stalled transfer changed");

endmodule

bind voxel_graph_cut_weight_generator vgcw_checker u_vgcw_checker (.*);
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voxel_graph_cut_weight_generator. Voxel volumes of
// several geometries are streamed in raster order through the valid/stall
// ports. Each result is checked field by field against an in-bench model of
// node index, source and sink cost, Gaussian link weights and end of volume.
// Both sides idle at random. One phase holds the output off so that the block
// stalls its input. The geometry registers are written and read back only
// between complete volumes.
// ----------------------------------------------------------------------------
module tb
    import vgcw_pkg::*;
();

    localparam int DIM_MAX    = 512;
    localparam int STORE_SIZE = DIM_MAX * DIM_MAX;
    localparam logic [63:0] FS = 64'd65535;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_valid;
    logic                i_stall;
    logic [NODE_W-1:0]   o_node_index;
    logic [SOURCE_W-1:0] o_source_weight;
    logic [SINK_W-1:0]   o_sink_weight;
    logic [WEIGHT_W-1:0] o_left_weight;
    logic                o_left_valid;
    logic [WEIGHT_W-1:0] o_up_weight;
    logic                o_up_valid;
    logic [WEIGHT_W-1:0] o_back_weight;
    logic                o_back_valid;
    logic                o_volume_done;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    voxel_graph_cut_weight_generator dut (.*);

    // model state
    logic [63:0]         ln_q56 [1:LEVELS];
    logic [15:0]         slice_mem [STORE_SIZE];
    logic [15:0]         prev_sample;
    int unsigned         col_pos, row_pos, slc_pos;
    logic [CFG_W-1:0]    cfg_cols, cfg_rows, cfg_slices;

    t_result             pending_q [$];
    bit                  failed;
    bit                  send_jitter;
    bit                  stall_jitter;
    int                  hold_left;
    logic [15:0]         walk_sample;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] atanh_series(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] one;
        logic [63:0] t;
        logic [63:0] acc;
        one = 64'd1 << 56;
        t   = (one / b) * a + ((one % b) * a) / b;
        acc = '0;
        for (int n = 0; n < 64 && t != 0; n++) begin
            acc = acc + t / (2 * n + 1);
            t   = (t * a) / b;
            t   = (t * a) / b;
        end
        return acc;
    endfunction

    function automatic void build_ln_levels();
        logic [63:0] ln2;
        logic [63:0] m;
        logic [63:0] e;
        ln2 = 64'd2 * atanh_series(64'd1, 64'd3);
        for (int k = 1; k <= LEVELS; k++) begin
            m = k;
            e = 0;
            while (m <= 100) begin
                m = m << 1;
                e = e + 1;
            end
            ln_q56[k] = e * ln2 + 64'd2 * atanh_series(200 - m, 200 + m);
        end
    endfunction

    function automatic logic [WEIGHT_W-1:0] gauss_level(input logic [15:0] a,
                                                        input logic [15:0] b);
        logic [63:0]  d;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [WEIGHT_W-1:0] w;
        d   = (a > b) ? 64'(a - b) : 64'(b - a);
        lhs = 128'(d * d) << 59;
        w   = '0;
        for (int k = 1; k <= LEVELS; k++) begin
            rhs = 128'(FS * FS) * 128'(ln_q56[k]);
            if (lhs <= rhs) w++;
        end
        return w;
    endfunction

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    function automatic t_result voxel_weights(input logic [15:0] s);
        t_result     r;
        int unsigned cols, rws, sls, p, src;
        cols = eff_dim(cfg_cols);
        rws  = eff_dim(cfg_rows);
        sls  = eff_dim(cfg_slices);
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= rws) row_pos = 0;
        if (slc_pos >= sls) slc_pos = 0;
        p   = row_pos * cols + col_pos;
        src = (s * 25) >> 5;
        r.node_index    = NODE_W'(slc_pos * rws * cols + p);
        r.source_weight = (src > SOURCE_LIMIT) ? SOURCE_LIMIT : SOURCE_W'(src);
        r.left_valid    = col_pos > 0;
        r.left_weight   = r.left_valid ? gauss_level(s, prev_sample) : '0;
        r.up_valid      = row_pos > 0;
        r.up_weight     = r.up_valid ? gauss_level(s, slice_mem[p - cols]) : '0;
        r.back_valid    = slc_pos > 0;
        r.back_weight   = r.back_valid ? gauss_level(s, slice_mem[p]) : '0;
        r.volume_done   = col_pos == cols - 1 && row_pos == rws - 1 && slc_pos == sls - 1;
        slice_mem[p] = s;
        prev_sample  = s;
        col_pos++;
        if (col_pos == cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos == rws) begin
                row_pos = 0;
                slc_pos++;
                if (slc_pos == sls) slc_pos = 0;
            end
        end
        return r;
    endfunction

    // receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= stall_jitter && ($urandom_range(0, 99) < 35);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_node_index, o_source_weight, o_left_weight, o_left_valid,
                    o_up_weight, o_up_valid, o_back_weight, o_back_valid, o_volume_done};
            if (pending_q.size() == 0) begin
                $display("%0t unexpected transfer: node %0d", $time, o_node_index);
                failed = 1'b1;
            end else begin
                want = pending_q.pop_front();
                if (got != want || o_sink_weight != SINK_COST) begin
                    $display("%0t exp node %0d src %0d sink %0d L %0d/%0b U %0d/%0b",
                             $time, want.node_index, want.source_weight, SINK_COST,
                             want.left_weight, want.left_valid, want.up_weight,
                             want.up_valid, " B %0d/%0b done %0b",
                             want.back_weight, want.back_valid, want.volume_done);
                    $display("%0t act node %0d src %0d sink %0d L %0d/%0b U %0d/%0b",
                             $time, got.node_index, got.source_weight, o_sink_weight,
                             got.left_weight, got.left_valid, got.up_weight,
                             got.up_valid, " B %0d/%0b done %0b",
                             got.back_weight, got.back_valid, got.volume_done);
                    failed = 1'b1;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_voxel(input logic [15:0] s);
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        pending_q.push_back(voxel_weights(s));
        @(negedge i_clk);
        if (send_jitter && $urandom_range(0, 99) < 35) begin
            i_valid  <= 1'b0;
            i_sample <= 16'($urandom);
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {22'($urandom), v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (addr)
            {REG_COLUMNS, 2'b00}: cfg_cols   = v;
            {REG_ROWS, 2'b00}:    cfg_rows   = v;
            {REG_SLICES, 2'b00}:  cfg_slices = v;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_check(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        paddr  <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== want) begin
            $display("%0t register 0x%0h exp %0d act %0d", $time, addr, want,
                     prdata[CFG_W-1:0]);
            failed = 1'b1;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r,
                                input logic [CFG_W-1:0] z);
        apb_write({REG_COLUMNS, 2'b00}, c);
        apb_write({REG_ROWS, 2'b00}, r);
        apb_write({REG_SLICES, 2'b00}, z);
        apb_check({REG_COLUMNS, 2'b00}, c);
        apb_check({REG_ROWS, 2'b00}, r);
        apb_check({REG_SLICES, 2'b00}, z);
    endtask

    // called at a falling edge
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic logic [15:0] next_walk(input bit wild);
        int span;
        int v;
        if (wild) return 16'($urandom);
        case ($urandom_range(0, 3))
            0: span = 3;
            1: span = 300;
            2: span = 5000;
            default: span = 25000;
        endcase
        v = int'(walk_sample) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, span));
        walk_sample = (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
        return walk_sample;
    endfunction

    task automatic stream_volume(input bit wild_mix);
        int unsigned n;
        n = eff_dim(cfg_cols) * eff_dim(cfg_rows) * eff_dim(cfg_slices);
        repeat (n) send_voxel(next_walk(wild_mix && $urandom_range(0, 99) < 20));
    endtask

    task automatic test_reset_values();
        apb_check({REG_COLUMNS, 2'b00}, DIM_RESET);
        apb_check({REG_ROWS, 2'b00}, DIM_RESET);
        apb_check({REG_SLICES, 2'b00}, DIM_RESET);
    endtask

    task automatic test_directed();
        logic [15:0] pat [12] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1,
                                  16'd0, 16'd0, 16'h8000, 16'd300, 16'd2600, 16'h7FFF};
        set_geometry(10'd3, 10'd2, 10'd2);
        foreach (pat[i]) send_voxel(pat[i]);
        // a second volume right behind the first one
        foreach (pat[i]) send_voxel(~pat[i]);
        drain();
        // unmapped address is ignored
        apb_write(4'hC, 10'd7);
        apb_check({REG_COLUMNS, 2'b00}, 10'd3);
        // zero acts as one
        set_geometry(10'd0, 10'd0, 10'd0);
        send_voxel(16'hFFFF);
        send_voxel(16'd0);
        drain();
    endtask

    task automatic test_extremes();
        set_geometry(10'd1023, 10'd1, 10'd1);
        stream_volume(1'b1);
        drain();
        set_geometry(10'd1, 10'd3, 10'd0);
        stream_volume(1'b1);
        drain();
        set_geometry(10'd0, 10'd1, 10'd4);
        stream_volume(1'b1);
        drain();
        set_geometry(10'd2, 10'd2, 10'd1);
        stream_volume(1'b1);
        drain();
    endtask

    task automatic test_random_volumes();
        repeat (4) begin
            set_geometry(10'($urandom_range(1, 10)), 10'($urandom_range(1, 8)),
                         10'($urandom_range(1, 6)));
            stream_volume(1'b1);
            drain();
        end
    endtask

    task automatic test_no_idle();
        send_jitter  = 1'b0;
        stall_jitter = 1'b0;
        set_geometry(10'd7, 10'd5, 10'd4);
        stream_volume(1'b0);
        drain();
        send_jitter  = 1'b1;
        stall_jitter = 1'b1;
    endtask

    task automatic test_backpressure();
        send_jitter = 1'b0;
        set_geometry(10'd6, 10'd4, 10'd5);
        @(posedge i_clk);
        hold_left = 300;
        @(negedge i_clk);
        stream_volume(1'b1);
        drain();
        send_jitter = 1'b1;
    endtask

    initial begin
        build_ln_levels();
        failed       = 1'b0;
        send_jitter  = 1'b1;
        stall_jitter = 1'b1;
        hold_left    = 0;
        walk_sample  = 16'h4000;
        prev_sample  = '0;
        col_pos      = 0;
        row_pos      = 0;
        slc_pos      = 0;
        cfg_cols     = DIM_RESET;
        cfg_rows     = DIM_RESET;
        cfg_slices   = DIM_RESET;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        i_stall      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed();
        test_extremes();
        test_random_volumes();
        test_no_idle();
        test_backpressure();
        drain();

        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
